FILE: rtl/mcs_pkg.sv
// Types and constants shared by the modem call sequencer modules.
package mcs_pkg;

    localparam int CNT_W   = 5;
    localparam int TIME_W  = 8;
    localparam int TC_W    = 4;
    localparam int DIAL_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [TC_W-1:0] UNMARKED_MIN = 4'd5;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SETUP   = 2'd1,
        PH_CONNECT = 2'd2,
        PH_MSG     = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_SETUP   = 3'd1,
        ACT_SEND_T  = 3'd2,
        ACT_DIAL    = 3'd3,
        ACT_CLOSE   = 3'd4,
        ACT_DELIVER = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        RS_NONE       = 3'd0,
        RS_NO_MODEM   = 3'd1,
        RS_NO_ANSWER  = 3'd2,
        RS_NO_CODES   = 3'd3,
        RS_UNEXPECTED = 3'd4,
        RS_BAD_REPLY  = 3'd5
    } t_reason;

    typedef enum logic [1:0] {
        EV_TICK = 2'd0,
        EV_POLL = 2'd1,
        EV_LINE = 2'd2,
        EV_NOP  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        LN_OK        = 3'd0,
        LN_CONNECT   = 3'd1,
        LN_OTHER     = 3'd2,
        LN_TIMECODE  = 3'd3,
        LN_UNMARKED  = 3'd4,
        LN_ONTIME    = 3'd5,
        LN_MALFORMED = 3'd6,
        LN_SPARE     = 3'd7
    } t_line;

    typedef enum logic [1:0] {
        PM_BACKUP = 2'd0,
        PM_AUTO   = 2'd1,
        PM_MANUAL = 2'd2,
        PM_SPARE  = 2'd3
    } t_poll_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL_MODE   = 3'd0,
        CFG_NUMBER_CNT  = 3'd1,
        CFG_SETUP_TO    = 3'd2,
        CFG_ANSWER_TO   = 3'd3,
        CFG_MESSAGE_TO  = 3'd4,
        CFG_REDIAL_TO   = 3'd5,
        CFG_MAX_CODES   = 3'd6,
        CFG_UNUSED      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_poll_mode        poll_mode;
        logic [CNT_W-1:0]  eff_count;
        logic [TIME_W-1:0] setup_to;
        logic [TIME_W-1:0] answer_to;
        logic [TIME_W-1:0] message_to;
        logic [TIME_W-1:0] redial_to;
        logic [TC_W-1:0]   max_codes;
    } t_cfg;

    typedef struct packed {
        t_action           action;
        logic [DIAL_W-1:0] dial;
        t_reason           reason;
        logic              sample;
        t_phase            phase;
    } t_result;

endpackage

FILE: rtl/mcs_cfg.sv
// Configuration registers with the number count clamped and zero timeouts raised to one.
module mcs_cfg
    import mcs_pkg::*;
#(
    parameter int MAX_NUMBERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg              r_cfg;
    logic [TIME_W-1:0] w_time;
    logic [CNT_W-1:0]  w_count;

    assign w_time  = (i_cfg_data == '0) ? TIME_W'(1) : i_cfg_data;
    assign w_count = (32'(i_cfg_data[CNT_W-1:0]) > MAX_NUMBERS) ?
                     CNT_W'(MAX_NUMBERS) : i_cfg_data[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_mode  <= PM_BACKUP;
            r_cfg.eff_count  <= '0;
            r_cfg.setup_to   <= TIME_W'(3);
            r_cfg.answer_to  <= TIME_W'(60);
            r_cfg.message_to <= TIME_W'(60);
            r_cfg.redial_to  <= TIME_W'(30);
            r_cfg.max_codes  <= TC_W'(10);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POLL_MODE:  r_cfg.poll_mode  <= t_poll_mode'(i_cfg_data[1:0]);
                CFG_NUMBER_CNT: r_cfg.eff_count  <= w_count;
                CFG_SETUP_TO:   r_cfg.setup_to   <= w_time;
                CFG_ANSWER_TO:  r_cfg.answer_to  <= w_time;
                CFG_MESSAGE_TO: r_cfg.message_to <= w_time;
                CFG_REDIAL_TO:  r_cfg.redial_to  <= w_time;
                CFG_MAX_CODES:  r_cfg.max_codes  <= i_cfg_data[TC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mcs_core.sv
// Call state registers and the single-pass next-state and result logic.
module mcs_core
    import mcs_pkg::*;
#(
    parameter int MAX_NUMBERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_mode,
    input  logic        i_force_call,
    input  logic        i_peer_selectable,
    input  logic [2:0]  i_line_class,
    output t_result     o_result
);

    localparam int IDX_W = $clog2(MAX_NUMBERS + 1);

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_countdown, n_countdown;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [TC_W-1:0]   r_tc, n_tc;

    t_result           w_res;
    logic              w_start, w_close, w_end;
    logic [IDX_W-1:0]  w_start_idx;
    t_action           w_close_act;
    t_reason           w_close_rsn;
    logic [TC_W-1:0]   w_tc_inc;

    assign w_tc_inc = r_tc + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_countdown = r_countdown;
        n_idx       = r_idx;
        n_tc        = r_tc;
        w_res.action = ACT_NONE;
        w_res.dial   = '0;
        w_res.reason = RS_NONE;
        w_res.sample = 1'b0;
        w_start     = 1'b0;
        w_close     = 1'b0;
        w_end       = 1'b0;
        w_start_idx = r_idx;
        w_close_act = ACT_CLOSE;
        w_close_rsn = RS_NONE;

        case (t_event'(i_mode))
            EV_TICK: begin
                if (r_countdown == '0) begin
                    w_start = i_force_call;
                end else begin
                    n_countdown = r_countdown - 1'b1;
                    if (r_countdown == TIME_W'(1)) begin
                        case (r_phase)
                            PH_IDLE:    w_start = 1'b1;
                            PH_SETUP: begin
                                w_close     = 1'b1;
                                w_close_rsn = RS_NO_MODEM;
                            end
                            PH_CONNECT: begin
                                w_close     = 1'b1;
                                w_close_rsn = RS_NO_ANSWER;
                            end
                            default:    w_end = 1'b1;
                        endcase
                    end
                end
            end
            EV_POLL: begin
                if (i_cfg.poll_mode != PM_MANUAL &&
                    !(i_cfg.poll_mode == PM_BACKUP && !i_peer_selectable)) begin
                    w_start     = 1'b1;
                    w_start_idx = '0;
                end
            end
            EV_LINE: begin
                case (r_phase)
                    PH_SETUP: begin
                        if (t_line'(i_line_class) == LN_OK &&
                            CNT_W'(r_idx) < i_cfg.eff_count) begin
                            w_res.action = ACT_DIAL;
                            w_res.dial   = DIAL_W'(r_idx);
                            n_idx        = IDX_W'(r_idx + 1'b1);
                            n_phase      = PH_CONNECT;
                            n_countdown  = i_cfg.answer_to;
                        end else begin
                            w_close     = 1'b1;
                            w_close_rsn = RS_UNEXPECTED;
                        end
                    end
                    PH_CONNECT: begin
                        if (t_line'(i_line_class) == LN_CONNECT) begin
                            n_phase     = PH_MSG;
                            n_countdown = i_cfg.message_to;
                        end else begin
                            w_close     = 1'b1;
                            w_close_rsn = RS_UNEXPECTED;
                        end
                    end
                    PH_MSG: begin
                        if (r_tc >= i_cfg.max_codes) begin
                            w_end = 1'b1;
                        end else begin
                            case (t_line'(i_line_class))
                                LN_TIMECODE: begin
                                    n_tc         = w_tc_inc;
                                    w_res.sample = 1'b1;
                                end
                                LN_UNMARKED: begin
                                    n_tc         = w_tc_inc;
                                    w_res.sample = (w_tc_inc >= UNMARKED_MIN);
                                end
                                LN_ONTIME:    w_res.sample = (r_tc != '0);
                                LN_MALFORMED: w_res.reason = RS_BAD_REPLY;
                                default: begin
                                end
                            endcase
                        end
                    end
                    default: begin
                        w_close     = 1'b1;
                        w_close_rsn = RS_UNEXPECTED;
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (w_end) begin
            w_close = 1'b1;
            if (r_tc == '0) begin
                w_close_act = ACT_CLOSE;
                w_close_rsn = RS_NO_CODES;
            end else begin
                w_close_act = ACT_DELIVER;
                w_close_rsn = RS_NONE;
            end
        end

        if (w_start) begin
            n_tc  = '0;
            n_idx = w_start_idx;
            if (CNT_W'(w_start_idx) >= i_cfg.eff_count) begin
                w_res.action = ACT_SEND_T;
                n_phase      = PH_MSG;
                n_countdown  = i_cfg.message_to;
            end else begin
                w_res.action = ACT_SETUP;
                n_phase      = PH_SETUP;
                n_countdown  = i_cfg.setup_to;
            end
        end

        if (w_close) begin
            w_res.action = w_close_act;
            w_res.reason = w_close_rsn;
            n_phase      = PH_IDLE;
            if (r_tc == '0 && r_idx != '0 && CNT_W'(r_idx) < i_cfg.eff_count) begin
                n_countdown = i_cfg.redial_to;
            end else begin
                n_countdown = '0;
            end
        end

        w_res.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_countdown <= '0;
            r_idx       <= '0;
            r_tc        <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_countdown <= n_countdown;
            r_idx       <= n_idx;
            r_tc        <= n_tc;
        end
    end

    assign o_result = w_res;

    a_active_has_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_countdown != '0)
        else $error("Active call phase with an expired countdown.");

    a_sample_in_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_res.sample |-> r_phase == PH_MSG)
        else $error("Sample passed outside the message phase.");

    a_dial_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && w_res.action == ACT_DIAL |=> r_phase == PH_CONNECT &&
        r_idx == IDX_W'($past(r_idx) + 1'b1))
        else $error("Dial did not move to connect with the next number.");

endmodule

FILE: rtl/modem_call_sequencer.sv
// Top level of the modem call sequencer: configuration, call logic and output skid buffer.
//
// Each input word is one event: a one-second tick, a system poll or a classified
// received line. Every accepted word yields exactly one result word carrying the
// action, the number to dial, a reason code, a sample flag and the call phase.
// Input words are taken when i_in_valid is high and o_in_stall is low; result
// words leave when o_out_valid is high and i_out_stall is low.
// The call state is updated in the cycle a word is accepted and the result is
// registered; one word per cycle is sustained while i_out_stall is low. A
// two-entry output buffer lets the block take a word while a result waits;
// o_in_stall rises only when both entries are full. Configuration writes through
// i_cfg_we, i_cfg_index and i_cfg_data take effect at once and must be made by
// the user while no call words are in flight; the block does not enforce this.
// Synchronous reset (i_rst_n low) returns the call to idle, clears the timer,
// number index and timecode count, loads the default register values and
// empties the output buffer.
module modem_call_sequencer
    import mcs_pkg::*;
#(
    parameter int MAX_NUMBERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic                  i_force_call,
    input  logic                  i_peer_selectable,
    input  logic [2:0]            i_line_class,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_action,
    output logic [DIAL_W-1:0]     o_dial_index,
    output logic [2:0]            o_reason,
    output logic                  o_sample_taken,
    output logic [1:0]            o_call_phase
);

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept, w_take;

    assign w_accept = i_in_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_out_stall;

    mcs_cfg #(
        .MAX_NUMBERS (MAX_NUMBERS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mcs_core #(
        .MAX_NUMBERS (MAX_NUMBERS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_cfg             (w_cfg),
        .i_mode            (i_mode),
        .i_force_call      (i_force_call),
        .i_peer_selectable (i_peer_selectable),
        .i_line_class      (i_line_class),
        .o_result          (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_action       = r_out.action;
    assign o_dial_index   = r_out.dial;
    assign o_reason       = r_out.reason;
    assign o_sample_taken = r_out.sample;
    assign o_call_phase   = r_out.phase;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry held while the output register is empty.");

    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("Stalled result word changed or was dropped.");

endmodule
